>>> hdl/lzss_pkg.sv
// lzss_pkg: shared types and constants for the lzss window decoder
// token operation codes, queue sizing and the token record passed from
// the front end through the queue to the back end
package lzss_pkg;

    // input command codes as they arrive on the stream
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_LIT   = 2'd1;
    localparam logic [1:0] CMD_PAIR  = 2'd2;

    // field widths fixed by the token format
    localparam int BYTE_W   = 8;
    localparam int PAIR_W   = 16;
    localparam int LEN_W    = 5;   // copy length 3..18
    localparam int DIST_W   = 13;  // distance 1..4096
    localparam int COUNT_W  = 32;
    localparam int LEN_BIAS = 3;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        OP_START,
        OP_LIT,
        OP_PAIR
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [BYTE_W-1:0]       lit;
        logic [LEN_W-1:0]        len;
        logic [DIST_W-1:0]       distance;
        logic                    static_bad; // length or distance beyond limits
    } token_t;

    typedef enum logic {
        BK_IDLE,
        BK_COPY
    } back_state_t;

endpackage

>>> hdl/lzss_ram.sv
// lzss_ram: generic single write port, single read port memory
// read data is registered; depends on nothing else
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/lzss_front.sv
// lzss_front: accepts stream transactions and classifies them into tokens
// uses lzss_pkg; feeds lzss_queue
module lzss_front #(
    parameter int HISTORY_DEPTH = 4096,
    parameter int MAX_MATCH     = 18
) (
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // literal_byte[7:0], pair_word[23:8]
    input  logic [1:0]            s_axis_tuser,   // cmd[1:0]
    input  logic                  queue_full,
    output logic                  push_valid,
    output lzss_pkg::token_t      push_token
);

    localparam logic [16:0] DEPTH_LIMIT = 17'(HISTORY_DEPTH);
    localparam logic [6:0]  MATCH_LIMIT = 7'(MAX_MATCH);

    logic [lzss_pkg::BYTE_W-1:0] lit_byte;
    logic [lzss_pkg::PAIR_W-1:0] pair_word;
    logic [lzss_pkg::LEN_W-1:0]  len;
    logic [lzss_pkg::DIST_W-1:0] distance;
    logic                        keep;
    lzss_pkg::op_t               op;

    assign lit_byte  = s_axis_tdata[7:0];
    assign pair_word = s_axis_tdata[23:8];

    // length and distance from the back-reference word
    assign len      = {1'b0, pair_word[15:12]} + lzss_pkg::LEN_W'(lzss_pkg::LEN_BIAS);
    assign distance = {1'b0, pair_word[11:0]} + lzss_pkg::DIST_W'(1);

    // command decode, unused code is dropped here
    always_comb
    begin
        keep = 1'b1;
        op   = lzss_pkg::OP_START;
        unique case (s_axis_tuser)
            lzss_pkg::CMD_START: op = lzss_pkg::OP_START;
            lzss_pkg::CMD_LIT:   op = lzss_pkg::OP_LIT;
            lzss_pkg::CMD_PAIR:  op = lzss_pkg::OP_PAIR;
            default:             keep = 1'b0;
        endcase
    end

    // token record into the queue
    always_comb
    begin
        push_token.op         = op;
        push_token.lit        = lit_byte;
        push_token.len        = len;
        push_token.distance   = distance;
        push_token.static_bad = ({4'b0, distance} > DEPTH_LIMIT)
                             || ({2'b0, len} > MATCH_LIMIT);
    end

    assign s_axis_tready = !queue_full;
    assign push_valid    = s_axis_tvalid && !queue_full && keep;

endmodule

>>> hdl/lzss_queue.sv
// lzss_queue: short token queue between the front and back ends
// uses lzss_pkg token record
module lzss_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lzss_pkg::token_t push_token,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output lzss_pkg::token_t pop_token
);

    lzss_pkg::token_t             entries_reg [lzss_pkg::QUEUE_DEPTH];
    logic [lzss_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [lzss_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [lzss_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign full      = (count_reg == lzss_pkg::QCNT_W'(lzss_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_token = entries_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // token storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

>>> hdl/lzss_back.sv
// lzss_back: executes tokens against the history memory and drives results
// uses lzss_pkg and one lzss_ram for the history window
module lzss_back #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      total_size,
    input  logic             q_valid,
    input  lzss_pkg::token_t q_token,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_byte[7:0]
    output logic             m_axis_tlast,   // last_of_run
    output logic [1:0]       m_axis_tuser    // stream_done[0], error[1]
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int SW = ((AW + 1 > lzss_pkg::DIST_W) ? AW + 1 : lzss_pkg::DIST_W) + 1;
    localparam logic [AW-1:0] ADDR_LAST = AW'(HISTORY_DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S   = SW'(HISTORY_DEPTH);

    lzss_pkg::back_state_t           state_reg, state_next;
    logic [lzss_pkg::COUNT_W-1:0]    bw_reg, bw_next;
    logic                            halted_reg, halted_next;
    logic [AW-1:0]                   wptr_reg, wptr_next;
    logic [AW-1:0]                   rptr_reg, rptr_next;
    logic [lzss_pkg::LEN_W-1:0]      cnt_reg, cnt_next;
    logic                            byp_reg, byp_next;
    logic [lzss_pkg::BYTE_W-1:0]     byp_data_reg, byp_data_next;
    logic                            out_valid_reg, out_valid_next;
    logic [lzss_pkg::BYTE_W-1:0]     out_byte_reg, out_byte_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_done_reg, out_done_next;
    logic                            out_err_reg, out_err_next;

    logic                            slot_free;
    logic                            tok_live;
    logic                            pair_bad;
    logic                            idle_take;
    logic                            copy_step;
    logic                            copy_last;
    logic [lzss_pkg::COUNT_W-1:0]    bw_inc;
    logic [lzss_pkg::COUNT_W-1:0]    remaining;
    logic [AW-1:0]                   wptr_inc;
    logic [AW-1:0]                   rptr_inc;
    logic [SW-1:0]                   src_diff;
    logic [AW-1:0]                   src_start;
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [lzss_pkg::BYTE_W-1:0]     ram_wdata;
    logic                            ram_re;
    logic [AW-1:0]                   ram_raddr;
    logic [lzss_pkg::BYTE_W-1:0]     ram_rdata;
    logic [lzss_pkg::BYTE_W-1:0]     hist_byte;

    // history window
    lzss_ram #(
        .WIDTH (lzss_pkg::BYTE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared status terms
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign tok_live  = !halted_reg && (bw_reg < total_size);
    assign remaining = total_size - bw_reg;
    assign pair_bad  = q_token.static_bad
                    || (lzss_pkg::COUNT_W'(q_token.distance) > bw_reg)
                    || (lzss_pkg::COUNT_W'(q_token.len) > remaining);
    assign idle_take = (state_reg == lzss_pkg::BK_IDLE) && q_valid && slot_free;
    assign copy_step = (state_reg == lzss_pkg::BK_COPY) && slot_free;
    assign copy_last = (cnt_reg == lzss_pkg::LEN_W'(1));
    assign bw_inc    = bw_reg + lzss_pkg::COUNT_W'(1);
    assign wptr_inc  = (wptr_reg == ADDR_LAST) ? '0 : wptr_reg + 1'b1;
    assign rptr_inc  = (rptr_reg == ADDR_LAST) ? '0 : rptr_reg + 1'b1;

    // first copy source, wrapped into the window
    assign src_diff  = SW'(wptr_reg) - SW'(q_token.distance);
    assign src_start = src_diff[SW-1] ? AW'(src_diff + DEPTH_S) : AW'(src_diff);

    // read data, forwarded when the byte was written in the read cycle
    assign hist_byte = byp_reg ? byp_data_reg : ram_rdata;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lzss_pkg::BK_IDLE:
            begin
                if (idle_take && tok_live && q_token.op == lzss_pkg::OP_PAIR && !pair_bad)
                begin
                    state_next = lzss_pkg::BK_COPY;
                end
            end
            lzss_pkg::BK_COPY:
            begin
                if (copy_step && copy_last)
                begin
                    state_next = lzss_pkg::BK_IDLE;
                end
            end
            default: state_next = lzss_pkg::BK_IDLE;
        endcase
    end

    // datapath and result register
    always_comb
    begin
        q_pop          = 1'b0;
        bw_next        = bw_reg;
        halted_next    = halted_reg;
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        cnt_next       = cnt_reg;
        byp_next       = byp_reg;
        byp_data_next  = byp_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        out_err_next   = out_err_reg;
        ram_we         = 1'b0;
        ram_waddr      = wptr_reg;
        ram_wdata      = q_token.lit;
        ram_re         = 1'b0;
        ram_raddr      = rptr_reg;

        unique case (state_reg)
            lzss_pkg::BK_IDLE:
            begin
                if (idle_take)
                begin
                    q_pop = 1'b1;
                    if (q_token.op == lzss_pkg::OP_START)
                    begin
                        bw_next     = '0;
                        halted_next = 1'b0;
                        wptr_next   = '0;
                    end
                    else if (tok_live && q_token.op == lzss_pkg::OP_LIT)
                    begin
                        ram_we         = 1'b1;
                        ram_wdata      = q_token.lit;
                        bw_next        = bw_inc;
                        wptr_next      = wptr_inc;
                        out_valid_next = 1'b1;
                        out_byte_next  = q_token.lit;
                        out_last_next  = 1'b1;
                        out_done_next  = (bw_inc == total_size);
                        out_err_next   = 1'b0;
                    end
                    else if (tok_live && q_token.op == lzss_pkg::OP_PAIR)
                    begin
                        if (pair_bad)
                        begin
                            halted_next    = 1'b1;
                            out_valid_next = 1'b1;
                            out_byte_next  = '0;
                            out_last_next  = 1'b1;
                            out_done_next  = 1'b0;
                            out_err_next   = 1'b1;
                        end
                        else
                        begin
                            // issue the first history read
                            ram_re        = 1'b1;
                            ram_raddr     = src_start;
                            rptr_next     = src_start;
                            cnt_next      = q_token.len;
                            byp_next      = 1'b0;
                            byp_data_next = q_token.lit;
                        end
                    end
                end
            end
            lzss_pkg::BK_COPY:
            begin
                if (copy_step)
                begin
                    // emit the fetched byte and store it at the write pointer
                    ram_we         = 1'b1;
                    ram_wdata      = hist_byte;
                    bw_next        = bw_inc;
                    wptr_next      = wptr_inc;
                    cnt_next       = cnt_reg - 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = hist_byte;
                    out_last_next  = copy_last;
                    out_done_next  = (bw_inc == total_size);
                    out_err_next   = 1'b0;
                    if (!copy_last)
                    begin
                        ram_re        = 1'b1;
                        ram_raddr     = rptr_inc;
                        rptr_next     = rptr_inc;
                        byp_next      = (rptr_inc == wptr_reg);
                        byp_data_next = hist_byte;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzss_pkg::BK_IDLE;
            bw_reg        <= '0;
            halted_reg    <= 1'b0;
            wptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bw_reg        <= bw_next;
            halted_reg    <= halted_next;
            wptr_reg      <= wptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rptr_reg     <= rptr_next;
        cnt_reg      <= cnt_next;
        byp_reg      <= byp_next;
        byp_data_reg <= byp_data_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
        out_err_reg  <= out_err_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_err_reg, out_done_reg};

endmodule

>>> hdl/lzss_window_decoder_top.sv
// channel     | dir | payload
// s_axis      | in  | tuser: cmd[1:0]; tdata: literal_byte[7:0], pair_word[23:8]
// m_axis      | out | tdata: out_byte[7:0]; tlast: last_of_run;
//             |     | tuser: stream_done[0], error[1]
// cfg         | in  | cfg_wdata: total_size, written when cfg_we is high
//
// the back end handles a literal or start in its idle state; a back-reference
// is first computed and checked, then copied one byte per cycle while the
// output is not stalled, through the single read port of the history memory
// a two-entry token queue lets the input keep accepting, until the queue is full, while the back end copies
// reset clears counters, halt flag and queue; history contents need no clearing
// a stalled result holds in the output register and freezes the copy in place
//
// top level: lzss window decoder, uses lzss_pkg, lzss_front, lzss_queue,
// lzss_back and lzss_ram
module lzss_window_decoder_top #(
    parameter int HISTORY_DEPTH = 4096,
    parameter int MAX_MATCH     = 18
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // literal_byte[7:0], pair_word[23:8]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic        m_axis_tlast,   // last_of_run
    output logic [1:0]  m_axis_tuser,   // stream_done[0], error[1]
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata       // total_size[31:0]
);

    logic [31:0]      total_size_reg;
    logic             push_valid;
    lzss_pkg::token_t push_token;
    logic             queue_full;
    logic             q_pop;
    logic             q_valid;
    lzss_pkg::token_t q_token;

    // total size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_size_reg <= '0;
        end
        else if (cfg_we)
        begin
            total_size_reg <= cfg_wdata;
        end
    end

    // token classification
    lzss_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_MATCH     (MAX_MATCH)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push_valid    (push_valid),
        .push_token    (push_token)
    );

    // token queue
    lzss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_token (push_token),
        .full       (queue_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_token  (q_token)
    );

    // token execution and history
    lzss_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .total_size    (total_size_reg),
        .q_valid       (q_valid),
        .q_token       (q_token),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> tb/lzss_checker.sv
`timescale 1ns / 100ps
// lzss_checker: watches the token, result and config channels of the lzss
// window decoder, predicts every decompressed byte and compares it; uses lzss_pkg
module lzss_checker #(
    parameter int HISTORY_DEPTH = 4096,
    parameter int MAX_MATCH     = 18
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // literal_byte[7:0], pair_word[23:8]
    input  logic [1:0]  s_tuser,    // cmd[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // out_byte[7:0]
    input  logic        m_tlast,    // last_of_run
    input  logic [1:0]  m_tuser,    // stream_done[0], error[1]
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending,
    output int          tokens_seen,
    output int          results_seen,
    output int          errors_seen,
    output int          streams_done
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
        logic       err;
    } out_byte_t;

    // predicted bytes waiting for their result transaction
    out_byte_t   expected_bytes[$];

    // mirror of the decoder state
    logic [7:0]  window [HISTORY_DEPTH];
    logic [31:0] total_size;
    logic [31:0] written;
    logic        halted;

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= 30)
            $display("mismatch at %0t ns: %s, got %0h, expected %0h", $time, what, got, want);
    endtask

    // store a byte in the window and queue its result
    task automatic emit_byte(input logic [7:0] data, input logic last);
        window[written % HISTORY_DEPTH] = data;
        written = written + 32'd1;
        expected_bytes.push_back(out_byte_t'{data, last, written == total_size, 1'b0});
    endtask

    task automatic decode_token(input logic [1:0] cmd, input logic [7:0] lit,
                                input logic [15:0] pair);
        logic [4:0]  len;
        logic [12:0] distance;
        logic [31:0] src;
        int          i;
        case (cmd)
            lzss_pkg::CMD_START:
            begin
                written = 32'd0;
                halted  = 1'b0;
            end
            lzss_pkg::CMD_LIT:
            begin
                if (!halted && written < total_size)
                    emit_byte(lit, 1'b1);
            end
            lzss_pkg::CMD_PAIR:
            begin
                if (!halted && written < total_size)
                begin
                    len      = {1'b0, pair[15:12]} + 5'd3;
                    distance = {1'b0, pair[11:0]} + 13'd1;
                    if (distance > written || distance > HISTORY_DEPTH || len > MAX_MATCH ||
                        len > total_size - written)
                    begin
                        // bad back-reference: single error byte, stream halts
                        halted = 1'b1;
                        expected_bytes.push_back(out_byte_t'{8'd0, 1'b1, 1'b0, 1'b1});
                    end
                    else
                    begin
                        // byte-wise copy so overlapping references repeat
                        for (i = 0; i < len; i++)
                        begin
                            src = written - distance;
                            emit_byte(window[src % HISTORY_DEPTH], i == len - 1);
                        end
                    end
                end
            end
            default: ;  // unused code is ignored
        endcase
    endtask

    task automatic check_result();
        out_byte_t want;
        results_seen++;
        if (m_tuser[1])
            errors_seen++;
        if (m_tuser[0])
            streams_done++;
        if (expected_bytes.size() == 0)
            report_mismatch("result with nothing expected", m_tdata, 0);
        else
        begin
            want = expected_bytes.pop_front();
            if (m_tdata !== want.data)
                report_mismatch("out_byte", m_tdata, want.data);
            if (m_tlast !== want.last)
                report_mismatch("last_of_run", m_tlast, want.last);
            if (m_tuser[0] !== want.done)
                report_mismatch("stream_done", m_tuser[0], want.done);
            if (m_tuser[1] !== want.err)
                report_mismatch("error", m_tuser[1], want.err);
        end
    endtask

    // results are compared before the token of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_bytes.delete();
            total_size   = 32'd0;
            written      = 32'd0;
            halted       = 1'b0;
            fail_count   = 0;
            pending      = 0;
            tokens_seen  = 0;
            results_seen = 0;
            errors_seen  = 0;
            streams_done = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (cfg_we)
                total_size = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                tokens_seen++;
                decode_token(s_tuser, s_tdata[7:0], s_tdata[23:8]);
            end
            pending = expected_bytes.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// testbench: token stimulus, back-pressure and verdict for lzss_window_decoder_top;
// depends on lzss_pkg and on lzss_checker for prediction and comparison
module testbench;

    localparam int HISTORY_DEPTH = 4096;
    localparam int MAX_MATCH     = 18;
    // longest quiet time of the back end: two queued full-length copies
    localparam int SETTLE_CYCLES = 2 * (MAX_MATCH + 1) + 8;
    localparam int STALL_LIMIT   = 2000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    int fail_count, pending, tokens_seen, results_seen, errors_seen, streams_done;
    int send_idle;
    int recv_idle;
    int cfg_writes;
    int quiet_cycles;

    // stream state as the generator sees it, used to shape legal references
    logic [31:0] gen_total;
    logic [31:0] gen_written;
    logic        gen_halted;

    lzss_window_decoder_top #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_MATCH     (MAX_MATCH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    lzss_checker #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_MATCH     (MAX_MATCH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_axis_tvalid),
        .s_tready     (s_axis_tready),
        .s_tdata      (s_axis_tdata),
        .s_tuser      (s_axis_tuser),
        .m_tvalid     (m_axis_tvalid),
        .m_tready     (m_axis_tready),
        .m_tdata      (m_axis_tdata),
        .m_tlast      (m_axis_tlast),
        .m_tuser      (m_axis_tuser),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .tokens_seen  (tokens_seen),
        .results_seen (results_seen),
        .errors_seen  (errors_seen),
        .streams_done (streams_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side back-pressure
    always @(negedge clk)
        m_axis_tready = rst_n && ($urandom_range(99) >= recv_idle);

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles = 0;
        else
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d cycles without a transaction", quiet_cycles);
                $display("FAIL lzss_window_decoder_top");
                $finish;
            end
        end
    end

    // track bytes written and halting so the generator can aim references
    task automatic note_token(input logic [1:0] cmd, input logic [15:0] pair);
        logic [31:0] len;
        logic [31:0] distance;
        len      = pair[15:12] + 3;
        distance = pair[11:0] + 1;
        if (cmd == lzss_pkg::CMD_START)
        begin
            gen_written = 32'd0;
            gen_halted  = 1'b0;
        end
        else if (!gen_halted && gen_written < gen_total)
        begin
            if (cmd == lzss_pkg::CMD_LIT)
                gen_written++;
            else if (cmd == lzss_pkg::CMD_PAIR)
            begin
                if (distance > gen_written || len > gen_total - gen_written)
                    gen_halted = 1'b1;
                else
                    gen_written += len;
            end
        end
    endtask

    // one token transaction, with random idle cycles in front of it
    task automatic send(input logic [1:0] cmd, input logic [7:0] lit, input logic [15:0] pair);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {pair, lit};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        note_token(cmd, pair);
    endtask

    // sender holds off until every predicted byte has come out
    task automatic wait_results();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_total(input logic [31:0] value);
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        gen_total = value;
        cfg_writes++;
    endtask

    task automatic random_token();
        int          pick;
        int          len;
        int          distance;
        logic [31:0] rem;
        int          max_dist;
        int          max_len;
        pick = $urandom_range(99);
        // stream over: mostly restart, sometimes a token that must be ignored
        if (gen_halted || gen_written >= gen_total)
        begin
            if (pick < 75)
                send(lzss_pkg::CMD_START, 8'($urandom), 16'($urandom));
            else
                send(pick < 88 ? lzss_pkg::CMD_LIT : lzss_pkg::CMD_PAIR,
                     8'($urandom), 16'($urandom));
            return;
        end
        rem      = gen_total - gen_written;
        max_dist = gen_written > HISTORY_DEPTH ? HISTORY_DEPTH : gen_written;
        max_len  = rem > MAX_MATCH ? MAX_MATCH : rem;
        if (pick < 5)
            send(CMD_UNUSED, 8'($urandom), 16'($urandom));
        else if (pick < 8)
            send(lzss_pkg::CMD_START, 8'($urandom), 16'($urandom));
        else if (pick < 15 && (rem < MAX_MATCH || gen_written < HISTORY_DEPTH))
        begin
            // broken reference: too long for what is left, or too far back
            if (rem < MAX_MATCH && $urandom_range(1))
            begin
                len      = $urandom_range(rem + 1, MAX_MATCH);
                distance = max_dist > 0 ? $urandom_range(1, max_dist) : 1;
            end
            else
            begin
                len      = $urandom_range(3, MAX_MATCH);
                distance = $urandom_range(gen_written + 1, HISTORY_DEPTH);
            end
            send(lzss_pkg::CMD_PAIR, 8'($urandom), {4'(len - 3), 12'(distance - 1)});
        end
        else if (pick < 55 || gen_written == 0 || rem < 3)
            send(lzss_pkg::CMD_LIT, 8'($urandom), 16'($urandom));
        else
        begin
            len = $urandom_range(3, max_len);
            if ($urandom_range(1))
                distance = $urandom_range(1, max_dist < 8 ? max_dist : 8);
            else
                distance = $urandom_range(1, max_dist);
            send(lzss_pkg::CMD_PAIR, 8'($urandom), {4'(len - 3), 12'(distance - 1)});
        end
    endtask

    // streams of random size, one total_size write in front of each
    task automatic run_streams(input int tokens);
        int sent;
        int run_len;
        int pick;
        sent = 0;
        while (sent < tokens)
        begin
            pick = $urandom_range(9);
            if (pick < 6)
                set_total($urandom_range(3, 60));
            else if (pick < 8)
                set_total($urandom_range(61, 300));
            else if (pick == 8)
                set_total(32'hFFFF_FFFF);
            else
                set_total($urandom_range(0, 2));
            send(lzss_pkg::CMD_START, 8'($urandom), 16'($urandom));
            run_len = $urandom_range(8, 30);
            for (int i = 0; i < run_len; i++)
            begin
                if (i == run_len / 2 && $urandom_range(3) == 0)
                    wait_results();
                random_token();
            end
            sent += run_len + 1;
        end
    endtask

    task automatic directed_tokens();
        // zero-length stream: every token is ignored
        set_total(32'd0);
        send(lzss_pkg::CMD_LIT, 8'h5A, 16'h0000);
        send(lzss_pkg::CMD_PAIR, 8'h00, 16'h0000);
        send(lzss_pkg::CMD_START, 8'h00, 16'h0000);
        send(lzss_pkg::CMD_LIT, 8'hFF, 16'hFFFF);

        set_total(32'd40);
        send(lzss_pkg::CMD_START, 8'hFF, 16'hFFFF);
        send(lzss_pkg::CMD_PAIR, 8'h00, 16'h0000);          // reference before any byte
        send(lzss_pkg::CMD_LIT, 8'h11, 16'h0000);           // ignored while halted
        send(CMD_UNUSED, 8'hFF, 16'hFFFF);
        send(lzss_pkg::CMD_START, 8'h00, 16'h0000);
        send(lzss_pkg::CMD_LIT, 8'h00, 16'hFFFF);
        send(lzss_pkg::CMD_LIT, 8'hFF, 16'h0000);
        send(lzss_pkg::CMD_PAIR, 8'h00, 16'h0000);          // overlapping copy, distance one
        send(lzss_pkg::CMD_PAIR, 8'hFF, {4'hF, 12'd4});     // longest copy
        send(CMD_UNUSED, 8'h3C, 16'h5A5A);
        send(lzss_pkg::CMD_PAIR, 8'h00, {4'h0, 12'd22});    // reaches back to the first byte
        send(lzss_pkg::CMD_PAIR, 8'h00, {4'hF, 12'd0});     // longer than what is left
        send(lzss_pkg::CMD_START, 8'h00, 16'h0000);         // window keeps old bytes
        send(lzss_pkg::CMD_LIT, 8'hA5, 16'h0000);
        send(lzss_pkg::CMD_PAIR, 8'h00, {4'hA, 12'd0});
        send(lzss_pkg::CMD_PAIR, 8'h00, 16'hFFFF);          // farthest distance, too far
        send(lzss_pkg::CMD_START, 8'h00, 16'h0000);
        send(lzss_pkg::CMD_LIT, 8'h3C, 16'h0000);
        send(lzss_pkg::CMD_PAIR, 8'h00, {4'hF, 12'd0});
        send(lzss_pkg::CMD_PAIR, 8'h00, {4'hF, 12'd1});
        send(lzss_pkg::CMD_PAIR, 8'h00, {4'h0, 12'd0});     // lands exactly on the total
        send(lzss_pkg::CMD_LIT, 8'h77, 16'h0000);           // after completion
        send(lzss_pkg::CMD_PAIR, 8'h00, 16'h0000);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 24'd0;
        s_axis_tuser  = lzss_pkg::CMD_START;
        cfg_we        = 1'b0;
        cfg_wdata     = 32'd0;
        send_idle     = 34;
        recv_idle     = 70;
        cfg_writes    = 0;
        gen_total     = 32'd0;
        gen_written   = 32'd0;
        gen_halted    = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // busy sender, heavily stalled receiver
        directed_tokens();
        run_streams(20);

        // sparse sender, lightly stalled receiver
        send_idle = 70;
        recv_idle = 34;
        run_streams(20);

        // no idling on either side
        send_idle = 0;
        recv_idle = 0;
        run_streams(15);

        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("ran %0d tokens into %0d result bytes, %0d error results, %0d streams done",
                 tokens_seen, results_seen, errors_seen, streams_done);
        $display("%0d total_size writes across three stall mixes, overlapping copies included",
                 cfg_writes);
        if (fail_count == 0 && pending == 0)
            $display("PASS lzss_window_decoder_top");
        else
            $display("FAIL lzss_window_decoder_top");
        $finish;
    end

endmodule

>>> lzss_window_decoder_top.f
hdl/lzss_pkg.sv
hdl/lzss_ram.sv
hdl/lzss_front.sv
hdl/lzss_queue.sv
hdl/lzss_back.sv
hdl/lzss_window_decoder_top.sv
tb/lzss_checker.sv
tb/testbench.sv
